// ===== rtl/core/tasa_pkg.sv =====
// ----------------------------------------------------------------------------
// tasa_pkg
// Shared types and constants of the trial average / deviation accumulator.
// ----------------------------------------------------------------------------
package tasa_pkg;

	localparam int MAX_CHANNELS = 64;
	localparam int MAX_WINDOW   = 1024;
	localparam logic [15:0] MAX_TRIALS = 16'hFFFF;

	localparam int CH_W   = 6;
	localparam int POS_W  = 10;
	localparam int IDX_W  = CH_W + POS_W;
	localparam int SUM_W  = 32;
	localparam int SQS_W  = 47;
	localparam int BIN_W  = SUM_W + SQS_W;
	localparam int BIN_DEPTH = MAX_CHANNELS * MAX_WINDOW;
	localparam int CNT_W  = 16;
	localparam int QUO_W  = 40;
	localparam int RAD_W  = 64;
	localparam int CFG_CH_W  = 7;
	localparam int CFG_WIN_W = 11;

	localparam logic [CFG_CH_W-1:0]  CH_RESET  = 7'd1;
	localparam logic [CFG_WIN_W-1:0] WIN_RESET = 11'd1024;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic REG_CHANNELS = 1'b0;
	localparam logic REG_WINDOW   = 1'b1;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         channel_index;
		logic [9:0]         sample_position;
		logic signed [23:0] mean_value;
		logic [23:0]        deviation_value;
		logic [15:0]        trials_counted;
		logic               trial_done;
		logic               accepted;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_MUL_LO, ST_MUL_HI, ST_DIFF,
		ST_ROOT_GO, ST_ROOT, ST_DEV_GO, ST_DEV, ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic update;
		logic mul_lo;
		logic mul_hi;
		logic diff;
		logic root_start;
		logic dev_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic root_busy;
		logic mean_busy;
		logic dev_busy;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/tasa_ram.sv =====
// ----------------------------------------------------------------------------
// tasa_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module tasa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/core/tasa_div.sv =====
// ----------------------------------------------------------------------------
// tasa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tasa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tasa_pkg::QUO_W-1:0]  dividend,
	input  logic [tasa_pkg::CNT_W-1:0]  divisor,
	output logic                        busy,
	output logic [tasa_pkg::QUO_W-1:0]  quotient
);
	import tasa_pkg::*;

	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [QUO_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic [CNT_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/tasa_root.sv =====
// ----------------------------------------------------------------------------
// tasa_root
// Digit-by-digit square root of radicand * 2^16, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tasa_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tasa_pkg::RAD_W-1:0]  radicand,
	output logic                        busy,
	output logic [tasa_pkg::QUO_W-1:0]  root
);
	import tasa_pkg::*;

	localparam int REM_W = QUO_W + 2;

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] root_q;
	logic [5:0]       cnt_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             fits;

	assign rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[QUO_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign root = root_q;
endmodule

// ===== rtl/core/tasa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tasa_ctrl
// Sequencer: accept, bin update, products, root, divide, deliver.
// ----------------------------------------------------------------------------
module tasa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	input  tasa_pkg::status_t status,
	output tasa_pkg::cmd_t    cmd,
	output logic              idle
);
	import tasa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_ADD) state_d = ST_READ;
			end
			ST_READ:    state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_ROOT_GO;
			ST_ROOT_GO: state_d = ST_ROOT;
			ST_ROOT: begin
				if (!status.root_busy) state_d = ST_DEV_GO;
			end
			ST_DEV_GO:  state_d = ST_DEV;
			ST_DEV: begin
				if (!status.dev_busy && !status.mean_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = state_q == ST_IDLE && in_valid && in_op == OP_ADD;
		cmd.clear      = state_q == ST_IDLE && in_valid && in_op == OP_CLEAR;
		cmd.update     = state_q == ST_READ;
		cmd.mul_lo     = state_q == ST_MUL_LO;
		cmd.mul_hi     = state_q == ST_MUL_HI;
		cmd.diff       = state_q == ST_DIFF;
		cmd.root_start = state_q == ST_ROOT_GO;
		cmd.dev_start  = state_q == ST_DEV_GO;
		cmd.load_out   = state_q == ST_FINISH && status.out_free;
	end

	assign idle = state_q == ST_IDLE;
endmodule

// ===== rtl/core/tasa_dp.sv =====
// ----------------------------------------------------------------------------
// tasa_dp
// Datapath: cursors, bin memory, products, root and divider units, output.
// ----------------------------------------------------------------------------
module tasa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tasa_pkg::cmd_t                  cmd,
	input  logic                            cfg_clear,
	input  logic [tasa_pkg::CFG_CH_W-1:0]   cfg_channels,
	input  logic [tasa_pkg::CFG_WIN_W-1:0]  cfg_window,
	input  logic signed [15:0]              sample,
	input  logic                            out_stall,
	output tasa_pkg::status_t               status,
	output logic                            out_valid,
	output tasa_pkg::out_item_t             out_data
);
	import tasa_pkg::*;

	logic [CFG_CH_W-1:0]  nch;
	logic [CFG_WIN_W-1:0] nwin;
	logic [CH_W-1:0]      ch_cur_q, ch_w;
	logic [POS_W-1:0]     pos_cur_q, pos_w;
	logic [CNT_W-1:0]     trial_q;
	logic                 wrap, ok_w, done_w, pos_last, ch_last;

	logic [IDX_W-1:0]     idx_q;
	logic [CH_W-1:0]      ch_q;
	logic [POS_W-1:0]     pos_q;
	logic [CNT_W-1:0]     n_q;
	logic                 ok_q, done_q, first_q;
	logic [31:0]          xsq_q;
	logic signed [31:0]   xsq_w;
	logic signed [SUM_W-1:0] x_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_addr;
	logic [BIN_W-1:0]     ram_rd;
	logic signed [SUM_W-1:0] rd_s, s_new, s_q;
	logic [SQS_W-1:0]     rd_q, q_new, q_q;

	logic [SUM_W-1:0]     mag_w;
	logic                 neg_q;
	logic [RAD_W-1:0]     sq_q, prod_q, d_q;

	logic [QUO_W-1:0]     mean_quo, dev_quo, root_w;
	logic [QUO_W-1:0]     mean_signed;
	logic                 out_valid_q;
	out_item_t            out_q;

	// saturate register values into the legal range
	always_comb begin
		nch  = (cfg_channels == '0) ? CFG_CH_W'(1)
			: (cfg_channels > CFG_CH_W'(MAX_CHANNELS)) ? CFG_CH_W'(MAX_CHANNELS)
			: cfg_channels;
		nwin = (cfg_window == '0) ? CFG_WIN_W'(1)
			: (cfg_window > CFG_WIN_W'(MAX_WINDOW)) ? CFG_WIN_W'(MAX_WINDOW)
			: cfg_window;
	end

	assign wrap     = {1'b0, ch_cur_q} >= nch || {1'b0, pos_cur_q} >= nwin;
	assign ch_w     = wrap ? '0 : ch_cur_q;
	assign pos_w    = wrap ? '0 : pos_cur_q;
	assign ch_last  = {1'b0, ch_w} + CFG_CH_W'(1) >= nch;
	assign pos_last = {1'b0, pos_w} + CFG_WIN_W'(1) >= nwin;
	assign done_w   = ch_last && pos_last;
	assign ok_w     = trial_q != MAX_TRIALS;
	assign xsq_w    = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_cur_q  <= '0;
			pos_cur_q <= '0;
			trial_q   <= '0;
		end else if (cfg_clear || cmd.clear) begin
			ch_cur_q  <= '0;
			pos_cur_q <= '0;
			trial_q   <= '0;
		end else if (cmd.accept) begin
			if (!pos_last) begin
				pos_cur_q <= pos_w + POS_W'(1);
				ch_cur_q  <= ch_w;
			end else begin
				pos_cur_q <= '0;
				if (!ch_last) begin
					ch_cur_q <= ch_w + CH_W'(1);
				end else begin
					ch_cur_q <= '0;
					if (ok_w) trial_q <= trial_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q   <= {ch_w, pos_w};
			ch_q    <= ch_w;
			pos_q   <= pos_w;
			done_q  <= done_w;
			ok_q    <= ok_w;
			first_q <= trial_q == '0;
			n_q     <= ok_w ? trial_q + CNT_W'(1) : trial_q;
			x_q     <= SUM_W'(sample);
			xsq_q   <= $unsigned(xsq_w);
		end
	end

	assign ram_we   = cmd.update && ok_q;
	assign ram_addr = cmd.accept ? {ch_w, pos_w} : idx_q;

	tasa_ram #(
		.WIDTH(BIN_W),
		.DEPTH(BIN_DEPTH)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({s_new, q_new}),
		.rdata(ram_rd)
	);

	assign rd_s = ram_rd[BIN_W-1:SQS_W];
	assign rd_q = ram_rd[SQS_W-1:0];

	always_comb begin
		if (!ok_q) begin
			s_new = rd_s;
			q_new = rd_q;
		end else if (first_q) begin
			s_new = x_q;
			q_new = SQS_W'(xsq_q);
		end else begin
			s_new = rd_s + x_q;
			q_new = rd_q + SQS_W'(xsq_q);
		end
	end

	assign mag_w = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			s_q <= s_new;
			q_q <= q_new;
		end
		if (cmd.mul_lo) begin
			neg_q  <= s_q[SUM_W-1];
			sq_q   <= RAD_W'(mag_w * mag_w);
			prod_q <= RAD_W'(n_q * q_q[23:0]);
		end
		if (cmd.mul_hi) begin
			prod_q <= prod_q + (RAD_W'(n_q * q_q[SQS_W-1:24]) << 24);
		end
		if (cmd.diff) begin
			d_q <= (prod_q > sq_q) ? prod_q - sq_q : '0;
		end
	end

	tasa_div u_mean_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_lo),
		.dividend({mag_w, 8'b0}),
		.divisor (n_q),
		.busy    (status.mean_busy),
		.quotient(mean_quo)
	);

	tasa_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.radicand(d_q),
		.busy    (status.root_busy),
		.root    (root_w)
	);

	tasa_div u_dev_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.dev_start),
		.dividend(root_w),
		.divisor (n_q),
		.busy    (status.dev_busy),
		.quotient(dev_quo)
	);

	assign mean_signed = neg_q ? QUO_W'(-mean_quo) : mean_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.channel_index   <= ch_q;
			out_q.sample_position <= pos_q;
			out_q.mean_value      <= mean_signed[23:0];
			out_q.deviation_value <= dev_quo[23:0];
			out_q.trials_counted  <= n_q;
			out_q.trial_done      <= done_q;
			out_q.accepted        <= ok_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
endmodule

// ===== rtl/core/trial_average_stddev_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// trial_average_stddev_accumulator_unit
// Per-bin running mean and standard deviation over trial-locked samples.
// ----------------------------------------------------------------------------
// Sequence: an add transfer is accepted, then the bin is read and updated,
//   two partial products are formed, then a 40-step root and a 40-step divide.
// A new add is taken only once the root unit followed by the divider on the
//   root has finished; a clear gives no result.
// The result register lets the next item in while a result is still stalled.
// Reset: cursors and trial count clear, channels_in_use = 1,
//   window_length = 1024; bin memory is not cleared (first trial overwrites).
module trial_average_stddev_accumulator_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tasa_pkg::in_item_t   in_data,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output tasa_pkg::out_item_t  out_data,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import tasa_pkg::*;

	cmd_t                 cmd;
	status_t              status;
	logic                 idle;
	logic                 cfg_wr;
	logic [CFG_CH_W-1:0]  channels_q;
	logic [CFG_WIN_W-1:0] window_q;

	// register write completes in the access phase; pready is tied high
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= CH_RESET;
			window_q   <= WIN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_CHANNELS: channels_q <= pwdata[CFG_CH_W-1:0];
				REG_WINDOW:   window_q   <= pwdata[CFG_WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CHANNELS: prdata = 32'(channels_q);
			REG_WINDOW:   prdata = 32'(window_q);
			default:      prdata = '0;
		endcase
	end

	// only the idle controller takes a transfer
	assign in_stall = !idle;

	tasa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_data.operation),
		.status  (status),
		.cmd     (cmd),
		.idle    (idle)
	);

	// any register write restarts trial accumulation
	tasa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_clear   (cfg_wr),
		.cfg_channels(channels_q),
		.cfg_window  (window_q),
		.sample      (in_data.sample_value),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);
endmodule
